// File: rtl/core/bcm_pkg.sv
package bcm_pkg;

  localparam logic       MODE_COLLECT = 1'b0;
  localparam logic       MODE_READ    = 1'b1;

  localparam logic [1:0] STAT_MEAN = 2'd0;
  localparam logic [1:0] STAT_VAR  = 2'd1;
  localparam logic [1:0] STAT_DENS = 2'd2;

  localparam logic [2:0] REG_BASE_BEGIN  = 3'd0;
  localparam logic [2:0] REG_BASE_WIDTH  = 3'd1;
  localparam logic [2:0] REG_DIST_BEGIN  = 3'd2;
  localparam logic [2:0] REG_DIST_WIDTH  = 3'd3;
  localparam logic [2:0] REG_STAT_ENABLE = 3'd4;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               mode;
    logic               drop;
    logic               dens_ok;
    logic [15:0]        d;
    logic [15:0]        e;
    logic signed [15:0] src;
    logic [1:0]         stat;
    logic [5:0]         bb;
    logic [5:0]         db;
    logic               ok;
    logic               bok;
    logic [22:0]        base_coord;
    logic [22:0]        dist_coord;
  } item_t;

  typedef struct packed {
    logic        valid_res;
    logic [47:0] value;
    logic [22:0] base_coord;
    logic [22:0] dist_coord;
    logic [31:0] bin_count;
  } result_t;

  function automatic logic [2:0] eff_enable(input logic [2:0] en);
    logic [2:0] r;
    r = en;
    if (en[1]) r[0] = 1'b1;
    return r;
  endfunction

endpackage

// File: rtl/core/bcm_front.sv
module bcm_front import bcm_pkg::*; #(
  parameter int BASE_BINS = 64,
  parameter int DIST_BINS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               mode_i,
  input  logic signed [15:0] base_value_i,
  input  logic signed [15:0] source_value_i,
  input  logic [1:0]         statistic_i,
  input  logic [5:0]         base_bin_i,
  input  logic [5:0]         dist_bin_i,
  input  logic [15:0]        base_begin_i,
  input  logic [15:0]        base_width_i,
  input  logic [15:0]        dist_begin_i,
  input  logic [15:0]        dist_width_i,
  input  logic [2:0]         en_i,
  output logic               item_valid_o,
  output item_t              item_o,
  input  logic               item_take_i
);

  item_t       it;
  item_t       q_mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic [16:0] dd, ee;
  logic [21:0] bprod, dprod;
  logic [23:0] bc, dc;
  logic        bok, dbok;
  logic        wr, rd;

  always_comb begin
    dd    = {base_value_i[15], base_value_i} - {base_begin_i[15], base_begin_i};
    ee    = {source_value_i[15], source_value_i} - {dist_begin_i[15], dist_begin_i};
    bprod = 22'(base_bin_i) * 22'(base_width_i);
    dprod = 22'(dist_bin_i) * 22'(dist_width_i);
    bc    = {{8{base_begin_i[15]}}, base_begin_i} + {2'b0, bprod};
    dc    = {{8{dist_begin_i[15]}}, dist_begin_i} + {2'b0, dprod};
    bok   = 32'(base_bin_i) < 32'(BASE_BINS);
    dbok  = 32'(dist_bin_i) < 32'(DIST_BINS);
    it            = '0;
    it.mode       = mode_i;
    it.drop       = (base_width_i == 16'd0) || dd[16];
    it.dens_ok    = en_i[2] && (dist_width_i != 16'd0) && !ee[16];
    it.d          = dd[15:0];
    it.e          = ee[15:0];
    it.src        = source_value_i;
    it.stat       = statistic_i;
    it.bb         = base_bin_i;
    it.db         = dist_bin_i;
    it.bok        = bok;
    it.ok         = ((statistic_i == STAT_MEAN) && en_i[0] && bok) ||
                    ((statistic_i == STAT_VAR) && en_i[1] && bok) ||
                    ((statistic_i == STAT_DENS) && en_i[2] && bok && dbok);
    it.base_coord = bc[22:0];
    it.dist_coord = dc[22:0];
  end

  assign full         = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = q_mem_q[rd_ptr_q];
  assign wr           = push && !full;
  assign rd           = item_take_i && item_valid_o;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      q_mem_q[wr_ptr_q] <= it;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr) wr_ptr_q <= ~wr_ptr_q;
      if (rd) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// File: rtl/core/bcm_div.sv
module bcm_div import bcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        short_i,
  input  logic [47:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [47:0] quo_o
);

  logic [47:0] dv_q, quo_q;
  logic [31:0] rem_q, div_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] rs, rdiff;
  logic        qbit;

  always_comb begin
    rs    = {rem_q, dv_q[47]};
    rdiff = rs - {1'b0, div_q};
    qbit  = !rdiff[32];
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dv_q  <= short_i ? {dividend_i[15:0], 32'b0} : dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dv_q  <= {dv_q[46:0], 1'b0};
      rem_q <= qbit ? rdiff[31:0] : rs[31:0];
      quo_q <= {quo_q[46:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= short_i ? 6'd16 : 6'd48;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/core/bcm_back.sv
module bcm_back import bcm_pkg::*; #(
  parameter int BASE_BINS = 64,
  parameter int DIST_BINS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  en_i,
  input  logic [15:0] base_width_i,
  input  logic [15:0] dist_width_i,
  input  logic        item_valid_i,
  input  item_t       item_i,
  output logic        item_take_o,
  output logic        empty,
  input  logic        pop,
  output result_t     res_o
);

  localparam int DEPTH = BASE_BINS * DIST_BINS;
  localparam int BW    = $clog2(BASE_BINS);
  localparam int DW    = $clog2(DIST_BINS);
  localparam int AW    = $clog2(DEPTH);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIVB  = 4'd2;
  localparam logic [3:0] S_DIVD  = 4'd3;
  localparam logic [3:0] S_FETCH = 4'd4;
  localparam logic [3:0] S_UPD   = 4'd5;
  localparam logic [3:0] S_EVAL  = 4'd6;
  localparam logic [3:0] S_DIV1  = 4'd7;
  localparam logic [3:0] S_DIV2  = 4'd8;
  localparam logic [3:0] S_SQ    = 4'd9;

  logic [3:0]         state_q, state_d;
  logic [AW-1:0]      clr_q;
  item_t              it_q;
  logic [BW-1:0]      n_q;
  logic [DW-1:0]      m_q;
  logic               hit_q, neg_q;
  logic [31:0]        cnt_q;
  logic [47:0]        sq_q, e2_q, prod_q;
  logic signed [47:0] mean_q;

  logic [31:0]        cnt_mem [BASE_BINS];
  logic [39:0]        sum_mem [BASE_BINS];
  logic [47:0]        sq_mem  [BASE_BINS];
  logic [31:0]        dens_mem [DEPTH];
  logic [31:0]        cnt_rd_q, hist_rd_q;
  logic [39:0]        sum_rd_q;
  logic [47:0]        sq_rd_q;

  logic               base_we, dens_we, clearing;
  logic [BW-1:0]      base_addr;
  logic [AW-1:0]      dens_addr;
  logic [31:0]        cnt_wd, hist_wd;
  logic [39:0]        sum_wd;
  logic [47:0]        sq_wd;

  logic               div_start, div_short, div_done;
  logic [47:0]        div_a, quo;
  logic [31:0]        div_b;

  result_t            res_mem_q [2];
  logic               rwr_ptr_q, rrd_ptr_q;
  logic [1:0]         rcnt_q;
  logic               res_push, res_pop;
  result_t            res_d;

  logic [BW+5:0]      bb_ext;
  logic [DW+5:0]      db_ext;
  logic [40:0]        sum_t;
  logic [31:0]        ss;
  logic [48:0]        sq_t;
  logic [31:0]        cnt_eval;
  logic [47:0]        s256, s256_abs, mean_abs, msq, qneg;
  logic [23:0]        am;

  bcm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .short_i    (div_short),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  always_comb begin
    bb_ext    = {{BW{1'b0}}, item_i.bb};
    db_ext    = {{DW{1'b0}}, item_i.db};
    clearing  = (state_q == S_CLR);
    base_addr = clearing ? clr_q[BW-1:0] : n_q;
    dens_addr = clearing ? clr_q : (AW'(n_q) * AW'(DIST_BINS) + AW'(m_q));

    cnt_wd  = (cnt_rd_q == CNT_MAX) ? cnt_rd_q : cnt_rd_q + 32'd1;
    sum_t   = {sum_rd_q[39], sum_rd_q} + {{25{it_q.src[15]}}, it_q.src};
    ss      = 32'(it_q.src * it_q.src);
    sq_t    = {1'b0, sq_rd_q} + {17'b0, ss};
    sum_wd  = sum_rd_q;
    sq_wd   = sq_rd_q;
    if (en_i[0]) begin
      if (sum_t[40] != sum_t[39]) sum_wd = sum_t[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
      else sum_wd = sum_t[39:0];
    end
    if (en_i[1]) sq_wd = sq_t[48] ? {48{1'b1}} : sq_t[47:0];
    hist_wd = (hist_rd_q == CNT_MAX) ? hist_rd_q : hist_rd_q + 32'd1;
    if (clearing) begin
      cnt_wd  = '0;
      sum_wd  = '0;
      sq_wd   = '0;
      hist_wd = '0;
    end

    cnt_eval = it_q.bok ? cnt_rd_q : 32'd0;
    s256     = {sum_rd_q, 8'b0};
    s256_abs = sum_rd_q[39] ? -s256 : s256;
    qneg     = -quo;
    mean_abs = mean_q[47] ? 48'(-mean_q) : 48'(mean_q);
    am       = (mean_abs > 48'h80_0000) ? 24'h80_0000 : mean_abs[23:0];
    msq      = {16'b0, prod_q[47:16]};
  end

  always_comb begin
    state_d     = state_q;
    item_take_o = 1'b0;
    div_start   = 1'b0;
    div_short   = 1'b0;
    div_a       = '0;
    div_b       = '0;
    res_push    = 1'b0;
    res_d       = '0;
    base_we     = 1'b0;
    dens_we     = 1'b0;
    case (state_q)
      S_CLR: begin
        dens_we = 1'b1;
        base_we = clr_q < AW'(BASE_BINS);
        if (clr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (item_valid_i && rcnt_q != 2'd2) begin
          item_take_o = 1'b1;
          if (item_i.mode == MODE_READ) begin
            state_d = S_FETCH;
          end else if (item_i.drop) begin
            res_push = 1'b1;
          end else begin
            div_start = 1'b1;
            div_short = 1'b1;
            div_a     = {32'b0, item_i.d};
            div_b     = {16'b0, base_width_i};
            state_d   = S_DIVB;
          end
        end
      end
      S_DIVB: begin
        if (div_done) begin
          if (quo >= 48'(BASE_BINS)) begin
            res_push = 1'b1;
            state_d  = S_IDLE;
          end else if (it_q.dens_ok) begin
            div_start = 1'b1;
            div_short = 1'b1;
            div_a     = {32'b0, it_q.e};
            div_b     = {16'b0, dist_width_i};
            state_d   = S_DIVD;
          end else begin
            state_d = S_FETCH;
          end
        end
      end
      S_DIVD: begin
        if (div_done) state_d = S_FETCH;
      end
      S_FETCH: begin
        state_d = (it_q.mode == MODE_READ) ? S_EVAL : S_UPD;
      end
      S_UPD: begin
        base_we  = 1'b1;
        dens_we  = hit_q;
        res_push = 1'b1;
        state_d  = S_IDLE;
      end
      S_EVAL: begin
        if (!it_q.ok || cnt_eval == 32'd0) begin
          res_push        = 1'b1;
          res_d.valid_res = it_q.ok;
          res_d.base_coord = it_q.base_coord;
          res_d.dist_coord = it_q.dist_coord;
          res_d.bin_count = cnt_eval;
          state_d         = S_IDLE;
        end else begin
          div_start = 1'b1;
          div_b     = cnt_rd_q;
          div_a     = (it_q.stat == STAT_DENS) ? {hist_rd_q, 16'b0} : s256_abs;
          state_d   = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          if (it_q.stat == STAT_VAR) begin
            div_start = 1'b1;
            div_a     = sq_q;
            div_b     = cnt_q;
            state_d   = S_DIV2;
          end else begin
            res_push        = 1'b1;
            res_d.valid_res = 1'b1;
            res_d.value     = (it_q.stat == STAT_MEAN && neg_q) ? qneg : quo;
            res_d.base_coord = it_q.base_coord;
            res_d.dist_coord = it_q.dist_coord;
            res_d.bin_count = cnt_q;
            state_d         = S_IDLE;
          end
        end
      end
      S_DIV2: begin
        if (div_done) state_d = S_SQ;
      end
      S_SQ: begin
        res_push         = 1'b1;
        res_d.valid_res  = 1'b1;
        res_d.value      = (e2_q > msq) ? e2_q - msq : 48'd0;
        res_d.base_coord = it_q.base_coord;
        res_d.dist_coord = it_q.dist_coord;
        res_d.bin_count  = cnt_q;
        state_d          = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (base_we) begin
      cnt_mem[base_addr] <= cnt_wd;
      sum_mem[base_addr] <= sum_wd;
      sq_mem[base_addr]  <= sq_wd;
    end
    cnt_rd_q <= cnt_mem[base_addr];
    sum_rd_q <= sum_mem[base_addr];
    sq_rd_q  <= sq_mem[base_addr];
  end

  always_ff @(posedge clk_i) begin
    if (dens_we) begin
      dens_mem[dens_addr] <= hist_wd;
    end
    hist_rd_q <= dens_mem[dens_addr];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 48'(am) * 48'(am);
    if (item_take_o) begin
      it_q  <= item_i;
      n_q   <= bb_ext[BW-1:0];
      m_q   <= db_ext[DW-1:0];
      hit_q <= 1'b0;
    end
    if (state_q == S_DIVB && div_done) begin
      n_q <= quo[BW-1:0];
    end
    if (state_q == S_DIVD && div_done) begin
      hit_q <= (quo < 48'(DIST_BINS));
      m_q   <= quo[DW-1:0];
    end
    if (state_q == S_EVAL) begin
      cnt_q <= cnt_eval;
      sq_q  <= sq_rd_q;
      neg_q <= sum_rd_q[39];
    end
    if (state_q == S_DIV1 && div_done) begin
      mean_q <= neg_q ? $signed(qneg) : $signed(quo);
    end
    if (state_q == S_DIV2 && div_done) begin
      e2_q <= quo;
    end
    if (res_push) begin
      res_mem_q[rwr_ptr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_q     <= '0;
      rwr_ptr_q <= 1'b0;
      rrd_ptr_q <= 1'b0;
      rcnt_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      if (clearing) clr_q <= clr_q + AW'(1);
      if (res_push) rwr_ptr_q <= ~rwr_ptr_q;
      if (res_pop) rrd_ptr_q <= ~rrd_ptr_q;
      rcnt_q <= rcnt_q + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

  assign empty   = (rcnt_q == 2'd0);
  assign res_pop = pop && !empty;
  assign res_o   = res_mem_q[rrd_ptr_q];

`ifndef NO_ASSERTIONS
  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_push && rcnt_q == 2'd2 && !pop))
    else $error("result queue overflow");
  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !item_take_o)
    else $error("item taken during clearing pass");
  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIVB || state_q == S_DIVD ||
                  state_q == S_DIV1 || state_q == S_DIV2))
    else $error("divider finished outside a wait state");
`endif

endmodule

// File: rtl/core/binned_conditional_moments.sv
// Binned conditional moments: collect items (mode 0) bin base_value into
// BASE_BINS bins and accumulate count, sum, square sum and a 2-D density
// histogram; read items (mode 1) return mean, variance or density of a bin.
// Every item yields exactly one result; collect results are all zero.
// After reset the block runs a clearing pass over all BASE_BINS*DIST_BINS
// entries before it takes an item. One item is worked at a time by a shared
// 1-bit per cycle divider: a collect uses one division (two with density),
// a mean or density read one, a variance read two, an empty or disabled read
// none. A two-entry queue on each side decouples the ports.
module binned_conditional_moments import bcm_pkg::*; #(
  parameter int BASE_BINS = 64,
  parameter int DIST_BINS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               mode_i,
  input  logic signed [15:0] base_value_i,
  input  logic signed [15:0] source_value_i,
  input  logic [1:0]         statistic_i,
  input  logic [5:0]         base_bin_i,
  input  logic [5:0]         dist_bin_i,
  output logic               empty,
  input  logic               pop,
  output logic               valid_res_o,
  output logic signed [47:0] value_o,
  output logic signed [22:0] base_coord_o,
  output logic signed [22:0] dist_coord_o,
  output logic [31:0]        bin_count_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);

  logic [15:0] base_begin_q, base_width_q, dist_begin_q, dist_width_q;
  logic [2:0]  stat_enable_q, en;
  logic        item_valid, item_take;
  item_t       item;
  result_t     res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_begin_q  <= 16'd0;
      base_width_q  <= 16'd256;
      dist_begin_q  <= 16'd0;
      dist_width_q  <= 16'd256;
      stat_enable_q <= 3'd7;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE_BEGIN:  base_begin_q  <= cfg_data_i;
        REG_BASE_WIDTH:  base_width_q  <= cfg_data_i;
        REG_DIST_BEGIN:  dist_begin_q  <= cfg_data_i;
        REG_DIST_WIDTH:  dist_width_q  <= cfg_data_i;
        REG_STAT_ENABLE: stat_enable_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign en = eff_enable(stat_enable_q);

  bcm_front #(
    .BASE_BINS (BASE_BINS),
    .DIST_BINS (DIST_BINS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .mode_i         (mode_i),
    .base_value_i   (base_value_i),
    .source_value_i (source_value_i),
    .statistic_i    (statistic_i),
    .base_bin_i     (base_bin_i),
    .dist_bin_i     (dist_bin_i),
    .base_begin_i   (base_begin_q),
    .base_width_i   (base_width_q),
    .dist_begin_i   (dist_begin_q),
    .dist_width_i   (dist_width_q),
    .en_i           (en),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .item_take_i    (item_take)
  );

  bcm_back #(
    .BASE_BINS (BASE_BINS),
    .DIST_BINS (DIST_BINS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .base_width_i      (base_width_q),
    .dist_width_i      (dist_width_q),
    .item_valid_i      (item_valid),
    .item_i            (item),
    .item_take_o       (item_take),
    .empty             (empty),
    .pop               (pop),
    .res_o             (res)
  );

  assign valid_res_o  = res.valid_res;
  assign value_o      = $signed(res.value);
  assign base_coord_o = $signed(res.base_coord);
  assign dist_coord_o = $signed(res.dist_coord);
  assign bin_count_o  = res.bin_count;

endmodule
